/* hw/rtl/lpfe_pkg.sv */
package lpfe_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned OffW     = 17;
  localparam int unsigned HdrLen   = 10;
  localparam int unsigned SyncCount = 4;

  localparam logic [OffW-1:0] OffLenHi  = OffW'(HdrLen - 2);
  localparam logic [OffW-1:0] OffLenLo  = OffW'(HdrLen - 1);
  localparam logic [OffW-1:0] OffSyncEnd = OffW'(SyncCount);
  localparam logic [OffW-1:0] OffHdrEnd = OffW'(HdrLen);

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [ApbAddrW-1:0] RegSyncByteAddr = ApbAddrW'(0);
  localparam logic [ByteW-1:0]    SyncByteReset   = 8'hA0;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             start;
    logic             last;
    logic             hdr_done;
    logic             sync_match;
    logic [LenW-1:0]  length;
  } item_t;

endpackage

/* hw/rtl/lpfe_front.sv */
module lpfe_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lpfe_pkg::ByteW-1:0]   sync_byte_i,
  input  logic                         rx_valid_i,
  input  logic [lpfe_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                         queue_full_i,
  output logic                         push_o,
  output lpfe_pkg::item_t              item_o
);

  logic                         in_frame_q, in_frame_d;
  logic [lpfe_pkg::OffW-1:0]    offset_q, offset_d;
  logic [lpfe_pkg::LenW-1:0]    length_q, length_d;
  logic                         sync_match_q, sync_match_d;

  logic                         accept;
  logic                         match;
  logic                         frame_byte;
  logic [lpfe_pkg::OffW-1:0]    offset;
  logic [lpfe_pkg::LenW-1:0]    length;
  logic                         sync_match;
  logic                         last;

  assign accept     = rx_valid_i && !queue_full_i;
  assign match      = (rx_byte_i == sync_byte_i);
  assign frame_byte = in_frame_q || match;

  always_comb begin
    offset     = in_frame_q ? offset_q : '0;
    length     = in_frame_q ? length_q : '0;
    sync_match = in_frame_q ? sync_match_q : 1'b1;
    if (offset < lpfe_pkg::OffSyncEnd && !match) begin
      sync_match = 1'b0;
    end
    if (offset == lpfe_pkg::OffLenHi) begin
      length = {rx_byte_i, 8'h00};
    end else if (offset == lpfe_pkg::OffLenLo) begin
      length = {length[15:8], rx_byte_i};
    end
    last = (offset >= lpfe_pkg::OffLenLo) &&
           (offset == lpfe_pkg::OffLenLo + lpfe_pkg::OffW'(length));
  end

  always_comb begin
    in_frame_d   = in_frame_q;
    offset_d     = offset_q;
    length_d     = length_q;
    sync_match_d = sync_match_q;
    if (accept && frame_byte) begin
      in_frame_d   = !last;
      offset_d     = last ? '0 : offset + lpfe_pkg::OffW'(1);
      length_d     = length;
      sync_match_d = sync_match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      offset_q     <= '0;
      length_q     <= '0;
      sync_match_q <= 1'b1;
    end else begin
      in_frame_q   <= in_frame_d;
      offset_q     <= offset_d;
      length_q     <= length_d;
      sync_match_q <= sync_match_d;
    end
  end

  assign push_o              = accept && frame_byte;
  assign item_o.data         = rx_byte_i;
  assign item_o.start        = !in_frame_q;
  assign item_o.last         = last;
  assign item_o.hdr_done     = (offset >= lpfe_pkg::OffHdrEnd);
  assign item_o.sync_match   = sync_match;
  assign item_o.length       = length;

endmodule

/* hw/rtl/lpfe_queue.sv */
module lpfe_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lpfe_pkg::item_t  push_item_i,
  input  logic             pop_i,
  output lpfe_pkg::item_t  pop_item_o,
  output logic             full_o,
  output logic             empty_o
);

  lpfe_pkg::item_t                 mem_q [lpfe_pkg::QueueDepth];
  logic [lpfe_pkg::QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [lpfe_pkg::QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [lpfe_pkg::QueueCntW-1:0]  count_q, count_d;

  assign full_o     = (count_q == lpfe_pkg::QueueCntW'(lpfe_pkg::QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + lpfe_pkg::QueuePtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + lpfe_pkg::QueuePtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + lpfe_pkg::QueueCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - lpfe_pkg::QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* hw/rtl/lpfe_back.sv */
module lpfe_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         queue_empty_i,
  input  lpfe_pkg::item_t              item_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lpfe_pkg::ByteW-1:0]   frame_byte_o,
  output logic                         frame_start_o,
  output logic                         frame_last_o,
  output logic                         sync_ok_o,
  output logic [lpfe_pkg::LenW-1:0]    payload_length_o
);

  logic                        valid_q, valid_d;
  logic [lpfe_pkg::ByteW-1:0]  data_q;
  logic                        start_q;
  logic                        last_q;
  logic                        ok_q;
  logic [lpfe_pkg::LenW-1:0]   plen_q;

  assign pop_o   = !queue_empty_i && (!valid_q || !out_stall_i);
  assign valid_d = pop_o ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q  <= item_i.data;
      start_q <= item_i.start;
      last_q  <= item_i.last;
      ok_q    <= item_i.hdr_done && item_i.sync_match;
      plen_q  <= item_i.hdr_done ? item_i.length : '0;
    end
  end

  assign out_valid_o      = valid_q;
  assign frame_byte_o     = data_q;
  assign frame_start_o    = start_q;
  assign frame_last_o     = last_q;
  assign sync_ok_o        = ok_q;
  assign payload_length_o = plen_q;

endmodule

/* hw/rtl/length_prefixed_frame_extractor.sv */
// Byte-stream deframer. One received byte is taken per cycle whenever rx_stall_o is low;
// rx_stall_o rises only when the four-entry queue between the byte classifier and the
// output register is full, which happens only after the output side has stalled. Bytes
// seen while hunting that differ from sync_byte are dropped; every frame byte comes out
// as one transaction each, held in the queue and then in the output register that drives
// out_valid_o, with frame_start on header byte zero and frame_last on the final byte
// (header byte nine for a zero-length frame). sync_ok and payload_length are meaningful
// from frame offset ten onward and read as zero on earlier header bytes. sync_byte sits
// at APB address 0 and resets to 0xA0.
module length_prefixed_frame_extractor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpfe_pkg::ApbAddrW-1:0]   paddr,
  input  logic [lpfe_pkg::ApbDataW-1:0]   pwdata,
  output logic [lpfe_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  input  logic                            rx_valid_i,
  output logic                            rx_stall_o,
  input  logic [lpfe_pkg::ByteW-1:0]      rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lpfe_pkg::ByteW-1:0]      frame_byte_o,
  output logic                            frame_start_o,
  output logic                            frame_last_o,
  output logic                            sync_ok_o,
  output logic [lpfe_pkg::LenW-1:0]       payload_length_o
);

  logic [lpfe_pkg::ByteW-1:0]  sync_byte_q, sync_byte_d;
  logic                        reg_write;
  logic                        push;
  logic                        pop;
  logic                        queue_full;
  logic                        queue_empty;
  lpfe_pkg::item_t             push_item;
  lpfe_pkg::item_t             pop_item;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && (paddr == lpfe_pkg::RegSyncByteAddr);
  assign sync_byte_d = reg_write ? pwdata[lpfe_pkg::ByteW-1:0] : sync_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_byte_q <= lpfe_pkg::SyncByteReset;
    end else begin
      sync_byte_q <= sync_byte_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == lpfe_pkg::RegSyncByteAddr) begin
      prdata = {{(lpfe_pkg::ApbDataW - lpfe_pkg::ByteW){1'b0}}, sync_byte_q};
    end
  end

  assign rx_stall_o = queue_full;

  lpfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sync_byte_i  (sync_byte_q),
    .rx_valid_i   (rx_valid_i),
    .rx_byte_i    (rx_byte_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (push_item)
  );

  lpfe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .full_o      (queue_full),
    .empty_o     (queue_empty)
  );

  lpfe_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .queue_empty_i    (queue_empty),
    .item_i           (pop_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_byte_o     (frame_byte_o),
    .frame_start_o    (frame_start_o),
    .frame_last_o     (frame_last_o),
    .sync_ok_o        (sync_ok_o),
    .payload_length_o (payload_length_o)
  );

endmodule
